// ===== rtl/core/alunz_pkg.sv =====
package alunz_pkg;

    localparam int DATA_W  = 32;
    localparam int SHAMT_W = 5;
    localparam int CNT_W   = 5;
    localparam int FUNC_W  = 5;

    localparam logic [DATA_W-1:0] LOW_HALF  = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] HIGH_HALF = 32'hFFFF_0000;

    typedef enum logic [FUNC_W-1:0] {
        F_ADD = 5'd0,
        F_SUB = 5'd1,
        F_MUL = 5'd2,
        F_DIV = 5'd3,
        F_CMP = 5'd4,
        F_SHL = 5'd5,
        F_SHR = 5'd6,
        F_AND = 5'd7,
        F_OR  = 5'd8,
        F_XOR = 5'd9,
        F_NOT = 5'd10,
        F_LDL = 5'd11,
        F_LDH = 5'd12,
        F_JZ  = 5'd13,
        F_JP  = 5'd14,
        F_JN  = 5'd15,
        F_JNZ = 5'd16,
        F_JNP = 5'd17,
        F_JNN = 5'd18,
        F_JMP = 5'd19
    } func_t;

    typedef enum logic [1:0] {
        IT_ADD,
        IT_SUB,
        IT_MUL,
        IT_DIV
    } iter_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_RUN,
        S_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic              start;
        iter_op_t          op;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
    } iter_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] mq;
    } iter_rsp_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     result_valid;
        logic signed [DATA_W-1:0] remainder;
        logic                     remainder_valid;
        logic                     branch_taken;
        logic                     div_by_zero;
        logic                     negative_flag;
        logic                     zero_flag;
    } out_item_t;

endpackage

// ===== rtl/core/alunz_stream_if.sv =====
interface alunz_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/alunz_iter.sv =====
module alunz_iter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  alunz_pkg::iter_req_t  req,
    output alunz_pkg::iter_rsp_t  rsp
);

    localparam int W = alunz_pkg::DATA_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    alunz_pkg::iter_op_t         op_reg, op_next;
    logic [alunz_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]                acc_reg, acc_next;
    logic [W-1:0]                mq_reg, mq_next;
    logic [W-1:0]                y_reg, y_next;

    logic         sub;
    logic [W:0]   add_a;
    logic [W:0]   add_b;
    logic [W+1:0] sum;
    logic         div_ge;

    // shared 33-bit add/subtract
    always_comb
    begin
        sub    = (op_reg == alunz_pkg::IT_SUB) || (op_reg == alunz_pkg::IT_DIV);
        add_a  = (op_reg == alunz_pkg::IT_DIV) ? {acc_reg, mq_reg[W-1]} : {1'b0, acc_reg};
        add_b  = {1'b0, y_reg};
        sum    = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{(W+1){1'b0}}, sub};
        div_ge = sum[W+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mq_next   = mq_reg;
        y_next    = y_reg;

        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            case (req.op)
                alunz_pkg::IT_MUL:
                begin
                    acc_next = '0;
                    mq_next  = req.y;
                    y_next   = req.x;
                    cnt_next = '1;
                end
                alunz_pkg::IT_DIV:
                begin
                    acc_next = '0;
                    mq_next  = req.x;
                    y_next   = req.y;
                    cnt_next = '1;
                end
                default:
                begin
                    acc_next = req.x;
                    y_next   = req.y;
                    cnt_next = '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                alunz_pkg::IT_MUL:
                begin
                    if (mq_reg[0])
                        acc_next = sum[W-1:0];
                    mq_next = {1'b0, mq_reg[W-1:1]};
                    y_next  = {y_reg[W-2:0], 1'b0};
                end
                alunz_pkg::IT_DIV:
                begin
                    acc_next = div_ge ? sum[W-1:0] : add_a[W-1:0];
                    mq_next  = {mq_reg[W-2:0], div_ge};
                end
                default:
                begin
                    acc_next = sum[W-1:0];
                end
            endcase
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= alunz_pkg::IT_ADD;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mq_reg  <= mq_next;
        y_reg   <= y_next;
    end

    assign rsp.done = done_reg;
    assign rsp.acc  = acc_reg;
    assign rsp.mq   = mq_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("iter unit did not go busy after start");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == '0) |=> (done_reg && !busy_reg))
        else $error("iter unit missed done after last step");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("iter unit done while busy");

endmodule

// ===== rtl/core/alunz_ctrl.sv =====
module alunz_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    alunz_stream_if.sink         cmd,
    alunz_stream_if.source       rsp,
    output alunz_pkg::iter_req_t ireq,
    input  alunz_pkg::iter_rsp_t irsp
);

    localparam int W = alunz_pkg::DATA_W;

    alunz_pkg::ctrl_state_t       state_reg, state_next;
    logic [alunz_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [W-1:0]                 a_reg, a_next;
    logic [W-1:0]                 b_reg, b_next;
    logic [W-1:0]                 res_reg, res_next;
    logic [W-1:0]                 rem_reg, rem_next;
    logic                         rv_reg, rv_next;
    logic                         remv_reg, remv_next;
    logic                         taken_reg, taken_next;
    logic                         dz_reg, dz_next;
    logic                         setf_reg, setf_next;
    logic                         neg_reg, neg_next;
    logic                         zero_reg, zero_next;
    logic                         out_valid_reg, out_valid_next;
    alunz_pkg::out_item_t         out_reg, out_next;

    logic                           sa;
    logic                           sb;
    logic [W-1:0]                   a_mag;
    logic [W-1:0]                   b_mag;
    logic [alunz_pkg::SHAMT_W-1:0]  shamt;
    logic                           nf;
    logic                           zf;

    always_comb
    begin
        sa    = a_reg[W-1];
        sb    = b_reg[W-1];
        a_mag = sa ? (~a_reg + 1'b1) : a_reg;
        b_mag = sb ? (~b_reg + 1'b1) : b_reg;
        shamt = b_reg[alunz_pkg::SHAMT_W-1:0];
        nf    = setf_reg ? res_reg[W-1] : neg_reg;
        zf    = setf_reg ? (res_reg == '0) : zero_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        rem_next       = rem_reg;
        rv_next        = rv_reg;
        remv_next      = remv_reg;
        taken_next     = taken_reg;
        dz_next        = dz_reg;
        setf_next      = setf_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_next       = out_reg;
        cmd.ready      = 1'b0;
        ireq.start     = 1'b0;
        ireq.op        = alunz_pkg::IT_ADD;
        ireq.x         = a_reg;
        ireq.y         = b_reg;

        case (state_reg)
            alunz_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    func_next  = cmd.data.func;
                    a_next     = cmd.data.operand_a;
                    b_next     = cmd.data.operand_b;
                    state_next = alunz_pkg::S_ISSUE;
                end
            end
            alunz_pkg::S_ISSUE:
            begin
                res_next   = '0;
                rem_next   = '0;
                rv_next    = 1'b0;
                remv_next  = 1'b0;
                taken_next = 1'b0;
                dz_next    = 1'b0;
                setf_next  = 1'b0;
                state_next = alunz_pkg::S_FIN;
                case (func_reg)
                    alunz_pkg::F_ADD:
                    begin
                        ireq.start = 1'b1;
                        rv_next    = 1'b1;
                        setf_next  = 1'b1;
                        state_next = alunz_pkg::S_RUN;
                    end
                    alunz_pkg::F_SUB:
                    begin
                        ireq.start = 1'b1;
                        ireq.op    = alunz_pkg::IT_SUB;
                        rv_next    = 1'b1;
                        setf_next  = 1'b1;
                        state_next = alunz_pkg::S_RUN;
                    end
                    alunz_pkg::F_CMP:
                    begin
                        ireq.start = 1'b1;
                        ireq.op    = alunz_pkg::IT_SUB;
                        setf_next  = 1'b1;
                        state_next = alunz_pkg::S_RUN;
                    end
                    alunz_pkg::F_MUL:
                    begin
                        ireq.start = 1'b1;
                        ireq.op    = alunz_pkg::IT_MUL;
                        rv_next    = 1'b1;
                        setf_next  = 1'b1;
                        state_next = alunz_pkg::S_RUN;
                    end
                    alunz_pkg::F_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            dz_next = 1'b1;
                        end
                        else
                        begin
                            ireq.start = 1'b1;
                            ireq.op    = alunz_pkg::IT_DIV;
                            ireq.x     = a_mag;
                            ireq.y     = b_mag;
                            rv_next    = 1'b1;
                            remv_next  = 1'b1;
                            setf_next  = 1'b1;
                            state_next = alunz_pkg::S_RUN;
                        end
                    end
                    alunz_pkg::F_SHL:
                    begin
                        res_next  = a_reg << shamt;
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_SHR:
                    begin
                        res_next  = $unsigned($signed(a_reg) >>> shamt);
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_AND:
                    begin
                        res_next  = a_reg & b_reg;
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_OR:
                    begin
                        res_next  = a_reg | b_reg;
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_XOR:
                    begin
                        res_next  = a_reg ^ b_reg;
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_NOT:
                    begin
                        res_next  = ~a_reg;
                        rv_next   = 1'b1;
                        setf_next = 1'b1;
                    end
                    alunz_pkg::F_LDL:
                    begin
                        res_next = (a_reg & alunz_pkg::HIGH_HALF) | (b_reg & alunz_pkg::LOW_HALF);
                        rv_next  = 1'b1;
                    end
                    alunz_pkg::F_LDH:
                    begin
                        res_next = (a_reg & alunz_pkg::LOW_HALF)
                                 | {b_reg[W/2-1:0], {(W/2){1'b0}}};
                        rv_next  = 1'b1;
                    end
                    alunz_pkg::F_JZ:  taken_next = zero_reg;
                    alunz_pkg::F_JP:  taken_next = !neg_reg && !zero_reg;
                    alunz_pkg::F_JN:  taken_next = neg_reg;
                    alunz_pkg::F_JNZ: taken_next = !zero_reg;
                    alunz_pkg::F_JNP: taken_next = neg_reg || zero_reg;
                    alunz_pkg::F_JNN: taken_next = !neg_reg;
                    alunz_pkg::F_JMP: taken_next = 1'b1;
                    default:          taken_next = 1'b0;
                endcase
            end
            alunz_pkg::S_RUN:
            begin
                if (irsp.done)
                begin
                    if (func_reg == alunz_pkg::F_DIV)
                    begin
                        res_next = (sa ^ sb) ? (~irsp.mq + 1'b1) : irsp.mq;
                        rem_next = sa ? (~irsp.acc + 1'b1) : irsp.acc;
                    end
                    else
                    begin
                        res_next = irsp.acc;
                    end
                    state_next = alunz_pkg::S_FIN;
                end
            end
            alunz_pkg::S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_next.result          = rv_reg ? res_reg : '0;
                    out_next.result_valid    = rv_reg;
                    out_next.remainder       = remv_reg ? rem_reg : '0;
                    out_next.remainder_valid = remv_reg;
                    out_next.branch_taken    = taken_reg;
                    out_next.div_by_zero     = dz_reg;
                    out_next.negative_flag   = nf;
                    out_next.zero_flag       = zf;
                    neg_next                 = nf;
                    zero_next                = zf;
                    state_next               = alunz_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alunz_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alunz_pkg::S_IDLE;
            neg_reg       <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        rem_reg   <= rem_next;
        rv_reg    <= rv_next;
        remv_reg  <= remv_next;
        taken_reg <= taken_next;
        dz_reg    <= dz_next;
        setf_reg  <= setf_next;
        out_reg   <= out_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    a_run_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alunz_pkg::S_RUN && irsp.done) |=> (state_reg == alunz_pkg::S_FIN))
        else $error("sequencer missed iter unit done");

    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == alunz_pkg::S_FIN && !setf_reg) |=> ($stable(neg_reg) && $stable(zero_reg)))
        else $error("flags changed on a non-flag operation");

    a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.div_by_zero)
            |-> (!out_reg.result_valid && !out_reg.remainder_valid))
        else $error("write reported on zero divisor");

endmodule

// ===== rtl/core/alu_with_nz_flags_and_branch_test_unit.sv =====
// Channel  Role    Payload
// cmd      sink    func, operand_a, operand_b
// rsp      source  result, result_valid, remainder, remainder_valid,
//                  branch_taken, div_by_zero, negative_flag, zero_flag
//
// Mul and div make 32 passes through the shared add/sub unit, one per
// bit; add, sub and cmp also use it, while all other codes and a divide
// by zero finish without it.
// cmd.ready is high only while the sequencer is idle; the next transaction
// is taken in the cycle after the result is loaded into the output register.
// rst_n clears the flags, the sequencer and the output valid.
// A stalled rsp holds the result; a finished item waits until it drains.
module alu_with_nz_flags_and_branch_test_unit (
    input  logic           clk,
    input  logic           rst_n,
    alunz_stream_if.sink   cmd,
    alunz_stream_if.source rsp
);

    alunz_pkg::iter_req_t ireq;
    alunz_pkg::iter_rsp_t irsp;

    alunz_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .ireq  (ireq),
        .irsp  (irsp)
    );

    alunz_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .rsp   (irsp)
    );

endmodule
